@@ hdl/ffcra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffcra_pkg
// Shared types and constants for the first-fit contiguous run allocator:
// field widths, register indexes, reset values, scan states and result type.
// ----------------------------------------------------------------------------
package ffcra_pkg;

    // default geometry of the occupancy map
    localparam int DEF_MAX_BANKS = 4;
    localparam int DEF_MAX_SPOTS = 64;

    // number of banks that own a spot count register
    localparam int SPOT_REGS  = 4;
    localparam int SPOT_SEL_W = 2;

    // field widths
    localparam int LEN_W       = 7;
    localparam int BANK_CNT_W  = 3;
    localparam int SPOTS_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int OUT_BANK_W  = 2;
    localparam int OUT_START_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOTS_BANK0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOTS_BANK1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOTS_BANK2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOTS_BANK3 = 3'd4;

    // register reset values
    localparam logic [BANK_CNT_W-1:0] RST_BANK_COUNT = 3'd2;
    localparam logic [SPOTS_W-1:0]    RST_SPOTS [SPOT_REGS] = '{7'd5, 7'd10, 7'd0, 7'd0};

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

    // one allocation result
    typedef struct packed {
        logic                   found;
        logic [OUT_BANK_W-1:0]  bank_index;
        logic [OUT_START_W-1:0] start_index;
    } t_result;

endpackage

@@ hdl/first_fit_contiguous_run_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_contiguous_run_allocator_core
// First-fit allocator of runs of adjacent free spots over a banked bitmap.
// ----------------------------------------------------------------------------
// The occupancy map is a ring of MAX_SPOTS cells, each holding one spot column
// for every bank; the ring turns one spot per cycle while a request is being
// served and the sequencer reads the column at its head. A request is handled
// on its own: each searched bank costs one full lap of the ring, and a hit
// finishes its lap and then takes one more lap to mark the run. A request of
// zero length, or with no banks, skips the scan and goes straight to its
// result. The result sits in an output register, so the next request is taken
// while it waits.
// All spots are free after reset and are never released.
// ----------------------------------------------------------------------------
module first_fit_contiguous_run_allocator_core
    import ffcra_pkg::*;
#(
    parameter int MAX_BANKS = DEF_MAX_BANKS,
    parameter int MAX_SPOTS = DEF_MAX_SPOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  logic [LEN_W-1:0]       i_run_length,
    output logic                   o_rsp_valid,
    input  logic                   i_rsp_ready,
    output logic                   o_found,
    output logic [OUT_BANK_W-1:0]  o_bank_index,
    output logic [OUT_START_W-1:0] o_start_index
);

    localparam int RUN_W = $clog2(MAX_SPOTS + 1);
    localparam int LIM_W = $clog2(MAX_BANKS + 1);
    localparam int SAT_W = (SPOTS_W > RUN_W) ? SPOTS_W : RUN_W;
    localparam int BL_W  = (BANK_CNT_W > LIM_W) ? BANK_CNT_W : LIM_W;

    logic [BANK_CNT_W-1:0] r_bank_count;
    logic [SPOTS_W-1:0]    r_spots [SPOT_REGS];
    logic [SPOT_SEL_W-1:0] w_spot_sel;

    logic [BL_W-1:0]       w_bank_count_x;
    logic [LIM_W-1:0]      w_bank_limit;
    logic [RUN_W-1:0]      w_spot_limit [MAX_BANKS];

    logic [MAX_BANKS-1:0]  w_col [MAX_SPOTS];
    logic [MAX_BANKS-1:0]  w_set;
    logic                  w_shift;

    logic                  w_slot_free;
    logic                  w_res_valid;
    t_result               w_res;
    logic                  r_rsp_valid;
    t_result               r_rsp;

    // configuration registers
    assign w_spot_sel = SPOT_SEL_W'(i_cfg_index - CFG_SPOTS_BANK0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= RST_BANK_COUNT;
            r_spots      <= RST_SPOTS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index) inside
                CFG_BANK_COUNT: r_bank_count <= i_cfg_wdata[BANK_CNT_W-1:0];
                CFG_SPOTS_BANK0, CFG_SPOTS_BANK1, CFG_SPOTS_BANK2, CFG_SPOTS_BANK3: begin
                    r_spots[w_spot_sel] <= i_cfg_wdata[SPOTS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // saturate the bank count to the map size
    assign w_bank_count_x = BL_W'(r_bank_count);
    assign w_bank_limit   = (w_bank_count_x > BL_W'(MAX_BANKS)) ?
                            LIM_W'(MAX_BANKS) : LIM_W'(w_bank_count_x);

    // saturated spot count per bank, zero for banks without a register
    for (genvar b = 0; b < MAX_BANKS; b++) begin : g_limit
        if (b < SPOT_REGS) begin : g_reg
            logic [SAT_W-1:0] w_spots_x;
            assign w_spots_x       = SAT_W'(r_spots[b]);
            assign w_spot_limit[b] = (w_spots_x > SAT_W'(MAX_SPOTS)) ?
                                     RUN_W'(MAX_SPOTS) : RUN_W'(w_spots_x);
        end else begin : g_none
            assign w_spot_limit[b] = '0;
        end
    end

    // occupancy ring, head at cell zero, marked bits enter at the tail
    for (genvar j = 0; j < MAX_SPOTS; j++) begin : g_ring
        if (j == MAX_SPOTS - 1) begin : g_tail
            ffcra_cell #(
                .MAX_BANKS (MAX_BANKS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_col   (w_col[0]),
                .i_set   (w_set),
                .o_col   (w_col[j])
            );
        end else begin : g_body
            ffcra_cell #(
                .MAX_BANKS (MAX_BANKS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_col   (w_col[j+1]),
                .i_set   ('0),
                .o_col   (w_col[j])
            );
        end
    end

    // scan sequencer
    ffcra_scan #(
        .MAX_BANKS (MAX_BANKS),
        .MAX_SPOTS (MAX_SPOTS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_run_length (i_run_length),
        .i_bank_limit (w_bank_limit),
        .i_spot_limit (w_spot_limit),
        .i_head       (w_col[0]),
        .o_shift      (w_shift),
        .o_set        (w_set),
        .i_slot_free  (w_slot_free),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    // output register
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_rsp <= w_res;
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_found       = r_rsp.found;
    assign o_bank_index  = r_rsp.bank_index;
    assign o_start_index = r_rsp.start_index;

endmodule

@@ hdl/ffcra_cell.sv @@
// ----------------------------------------------------------------------------
// ffcra_cell
// One link of the occupancy ring: holds the occupied bits of one spot column
// across all banks and takes its neighbour's column on every shift.
// ----------------------------------------------------------------------------
module ffcra_cell
    import ffcra_pkg::*;
#(
    parameter int MAX_BANKS = DEF_MAX_BANKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [MAX_BANKS-1:0] i_col,
    input  logic [MAX_BANKS-1:0] i_set,
    output logic [MAX_BANKS-1:0] o_col
);

    logic [MAX_BANKS-1:0] r_col;
    logic [MAX_BANKS-1:0] n_col;

    // incoming column, with any newly occupied bits merged in
    assign n_col = i_col | i_set;

    // column storage, all spots free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ hdl/ffcra_scan.sv @@
// ----------------------------------------------------------------------------
// ffcra_scan
// Scan sequencer: watches the head of the rotating occupancy ring one spot
// per cycle, counts free runs, and marks the winning run on a later lap.
// ----------------------------------------------------------------------------
module ffcra_scan
    import ffcra_pkg::*;
#(
    parameter int MAX_BANKS = DEF_MAX_BANKS,
    parameter int MAX_SPOTS = DEF_MAX_SPOTS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_req_valid,
    output logic                                     o_req_ready,
    input  logic [LEN_W-1:0]                         i_run_length,
    input  logic [$clog2(MAX_BANKS+1)-1:0]           i_bank_limit,
    input  logic [$clog2(MAX_SPOTS+1)-1:0]           i_spot_limit [MAX_BANKS],
    input  logic [MAX_BANKS-1:0]                     i_head,
    output logic                                     o_shift,
    output logic [MAX_BANKS-1:0]                     o_set,
    input  logic                                     i_slot_free,
    output logic                                     o_res_valid,
    output t_result                                  o_res
);

    localparam int BANK_W   = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int POS_W    = $clog2(MAX_SPOTS);
    localparam int RUN_W    = $clog2(MAX_SPOTS + 1);
    localparam int LIM_W    = $clog2(MAX_BANKS + 1);
    localparam int CMP_W    = (RUN_W > LEN_W) ? RUN_W : LEN_W;
    localparam int BSUM_W   = ((LIM_W > BANK_W) ? LIM_W : BANK_W) + 1;
    localparam int BX_W     = (BANK_W > OUT_BANK_W) ? BANK_W : OUT_BANK_W;
    localparam int SX_W     = (POS_W > OUT_START_W) ? POS_W : OUT_START_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_SPOTS - 1);

    t_state             r_state, n_state;
    logic [BANK_W-1:0]  r_bank,  n_bank;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [RUN_W-1:0]   r_run,   n_run;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [POS_W-1:0]   r_start, n_start;
    logic [POS_W-1:0]   r_end,   n_end;
    logic               r_found, n_found;
    logic               r_marked, n_marked;

    logic               w_accept;
    logic               w_req_ok;
    logic               w_usable;
    logic               w_free;
    logic [CMP_W-1:0]   w_run_inc;
    logic               w_hit;
    logic               w_last_pos;
    logic               w_last_bank;
    logic               w_in_run;
    logic [POS_W-1:0]   w_pos_next;
    logic [CMP_W-1:0]   w_start_full;
    logic [BX_W-1:0]    w_bank_x;
    logic [SX_W-1:0]    w_start_x;

    // head spot status and run tracking
    assign w_accept     = i_req_valid && (r_state == ST_IDLE);
    assign w_req_ok     = (i_run_length != '0) && (i_bank_limit != '0);
    assign w_usable     = RUN_W'(r_pos) < i_spot_limit[r_bank];
    assign w_free       = !i_head[r_bank];
    assign w_run_inc    = CMP_W'(r_run) + CMP_W'(1);
    assign w_hit        = w_usable && w_free && (w_run_inc == CMP_W'(r_len));
    assign w_last_pos   = (r_pos == LAST_POS);
    assign w_last_bank  = (BSUM_W'(r_bank) + BSUM_W'(1)) >= BSUM_W'(i_bank_limit);
    assign w_in_run     = (r_pos >= r_start) && (r_pos <= r_end);
    assign w_pos_next   = w_last_pos ? '0 : r_pos + POS_W'(1);
    assign w_start_full = CMP_W'(r_pos) + CMP_W'(1) - CMP_W'(r_len);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_req_ok ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_MARK;
                end else if (w_last_pos && w_last_bank) begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                if (w_last_pos && (r_marked || r_pos == r_end)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // next datapath values
    always_comb begin
        n_bank   = r_bank;
        n_pos    = r_pos;
        n_run    = r_run;
        n_len    = r_len;
        n_start  = r_start;
        n_end    = r_end;
        n_found  = r_found;
        n_marked = r_marked;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_len    = i_run_length;
                    n_bank   = '0;
                    n_run    = '0;
                    n_found  = 1'b0;
                    n_marked = 1'b0;
                end
            end
            ST_SCAN: begin
                n_pos = w_pos_next;
                if (w_hit) begin
                    n_start = w_start_full[POS_W-1:0];
                    n_end   = r_pos;
                    n_found = 1'b1;
                end else if (w_last_pos) begin
                    n_run = '0;
                    if (!w_last_bank) begin
                        n_bank = r_bank + BANK_W'(1);
                    end
                end else if (w_usable) begin
                    n_run = w_free ? w_run_inc[RUN_W-1:0] : '0;
                end
            end
            ST_MARK: begin
                n_pos = w_pos_next;
                if (r_pos == r_end) begin
                    n_marked = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_found  <= 1'b0;
            r_marked <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_found  <= n_found;
            r_marked <= n_marked;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bank  <= n_bank;
        r_run   <= n_run;
        r_len   <= n_len;
        r_start <= n_start;
        r_end   <= n_end;
    end

    // outputs
    assign w_bank_x  = BX_W'(r_bank);
    assign w_start_x = SX_W'(r_start);

    always_comb begin
        o_req_ready       = (r_state == ST_IDLE);
        o_shift           = (r_state == ST_SCAN) || (r_state == ST_MARK);
        o_set             = '0;
        o_res_valid       = (r_state == ST_DONE) && i_slot_free;
        o_res.found       = r_found;
        o_res.bank_index  = r_found ? w_bank_x[OUT_BANK_W-1:0] : '0;
        o_res.start_index = r_found ? w_start_x[OUT_START_W-1:0] : '0;
        if ((r_state == ST_MARK) && w_in_run) begin
            o_set = MAX_BANKS'(1) << r_bank;
        end
    end

endmodule

@@ hdl/ffcra_chk.sv @@
// ----------------------------------------------------------------------------
// ffcra_chk
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ffcra_chk
    import ffcra_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   o_req_ready,
    input  logic                   o_rsp_valid,
    input  logic                   i_rsp_ready,
    input  logic                   o_found,
    input  logic [OUT_BANK_W-1:0]  o_bank_index,
    input  logic [OUT_START_W-1:0] o_start_index
);

    // a stalled result holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=>
            o_rsp_valid && $stable(o_found) && $stable(o_bank_index)
            && $stable(o_start_index))
        else $error("result changed while stalled");

    // a miss reports zero bank and start
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_found |-> o_bank_index == '0 && o_start_index == '0)
        else $error("miss with nonzero indices");

    // one request at a time: ready drops after an accepted request
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while busy");

    // reset leaves no result pending and the block ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("bad state after reset");

endmodule

bind first_fit_contiguous_run_allocator_core ffcra_chk u_ffcra_chk (.*);
